// ===== rtl/mssc_pkg.sv =====
// ----------------------------------------------------------------------------
// mssc_pkg
// shared types and constants of the motor speed step controller
// ----------------------------------------------------------------------------
package mssc_pkg;

    localparam int TargetW  = 8;
    localparam int PeriodW  = 10;
    localparam int WindowW  = 5;
    localparam int CountW   = 8;
    localparam int DutyW    = 10;
    localparam int PhaseW   = 11;

    localparam int ApbAddrW = 4;
    localparam int ApbDataW = 32;
    localparam int InDataW  = 8;
    localparam int OutDataW = 32;

    localparam logic [TargetW-1:0] HighTargetReset = 8'd120;
    localparam logic [TargetW-1:0] LowTargetReset  = 8'd75;
    localparam logic [PeriodW-1:0] PeriodReset     = 10'd256;
    localparam logic [WindowW-1:0] WindowReset     = 5'd20;

    localparam logic [TargetW-1:0] TargetReset = 8'd75;
    localparam logic [DutyW-1:0]   DutyReset   = 10'd34;
    localparam logic [DutyW-1:0]   DutyFloor   = 10'd2;
    localparam logic [CountW-1:0]  CountMax    = 8'd255;

    typedef enum logic [1:0] {
        REG_HIGH_TARGET  = 2'd0,
        REG_LOW_TARGET   = 2'd1,
        REG_PWM_PERIOD   = 2'd2,
        REG_WINDOW_TICKS = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [TargetW-1:0] high_target;
        logic [TargetW-1:0] low_target;
        logic [PeriodW-1:0] pwm_period;
        logic [WindowW-1:0] window_ticks;
    } cfg_t;

    // input item, last field lowest in tdata
    typedef struct packed {
        logic high_button_n;
        logic low_button_n;
        logic pwm_tick;
        logic slow_tick;
        logic tach_pulse;
    } in_item_t;

    // result item, last field lowest in tdata
    typedef struct packed {
        logic [TargetW-1:0] active_target;
        logic [DutyW-1:0]   duty_count;
        logic [CountW-1:0]  measured_speed;
        logic               drive_level;
    } out_item_t;

endpackage

// ===== rtl/motor_speed_step_controller.sv =====
// an accepted item is registered in the input register, its result in the output register
// throughput: one item per cycle while the output is not stalled, limited by the single state update stage
// a stalled output holds its result while one more item waits in the input register
// reset (rst_n, async, active low) empties both stages and restores state and registers
// ----------------------------------------------------------------------------
// motor_speed_step_controller
// tach pulse counting over a tick window, duty stepping and accumulator pwm
// ----------------------------------------------------------------------------
module motor_speed_step_controller
    import mssc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ApbAddrW-1:0] paddr,
    input  logic [ApbDataW-1:0] pwdata,
    output logic [ApbDataW-1:0] prdata,
    output logic                pready,

    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // tach_pulse, slow_tick, pwm_tick, low_button_n, high_button_n, zero pad
    input  logic [InDataW-1:0]  s_axis_tdata,

    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // drive_level, measured_speed, duty_count, active_target, zero pad
    output logic [OutDataW-1:0] m_axis_tdata
);

    cfg_t cfg;

    logic      in_valid_reg;
    logic      in_valid_next;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_item_reg;
    logic      adv;
    logic      s_xfer;

    logic [CountW-1:0]  pulse_count_reg;
    logic [CountW-1:0]  pulse_count_next;
    logic [CountW-1:0]  speed_reg;
    logic [CountW-1:0]  speed_next;
    logic [WindowW-1:0] tick_count_reg;
    logic [WindowW-1:0] tick_count_next;
    logic [TargetW-1:0] target_reg;
    logic [TargetW-1:0] target_next;
    logic [DutyW-1:0]   duty_reg;
    logic [DutyW-1:0]   duty_next;
    logic [PhaseW-1:0]  phase_reg;
    logic [PhaseW-1:0]  phase_next;
    logic               drive_reg;
    logic               drive_next;

    logic [CountW-1:0]  pulse_inc;
    logic [WindowW:0]   tick_inc;
    logic [PhaseW:0]    phase_sum;

    mssc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready = 1'b1;

    assign adv           = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || adv;
    assign s_xfer        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OutDataW-$bits(out_item_t)){1'b0}}, out_item_reg};

    always_comb
    begin
        in_valid_next  = s_xfer ? 1'b1 : (adv ? 1'b0 : in_valid_reg);
        out_valid_next = adv ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);
    end

    // one step: tach pulse, then slow tick, then pwm tick
    always_comb
    begin
        pulse_inc        = pulse_count_reg;
        pulse_count_next = pulse_count_reg;
        speed_next       = speed_reg;
        tick_count_next  = tick_count_reg;
        target_next      = target_reg;
        duty_next        = duty_reg;
        phase_next       = phase_reg;
        drive_next       = drive_reg;
        tick_inc         = {1'b0, tick_count_reg} + {{WindowW{1'b0}}, 1'b1};
        phase_sum        = '0;

        if (in_item_reg.tach_pulse && (pulse_count_reg != CountMax))
        begin
            pulse_inc = pulse_count_reg + {{(CountW-1){1'b0}}, 1'b1};
        end
        pulse_count_next = pulse_inc;

        if (in_item_reg.slow_tick)
        begin
            if (tick_inc < {1'b0, cfg.window_ticks})
            begin
                tick_count_next = tick_inc[WindowW-1:0];
                if (!in_item_reg.low_button_n)
                begin
                    target_next = cfg.low_target;
                end
                else if (!in_item_reg.high_button_n)
                begin
                    target_next = cfg.high_target;
                end
            end
            else
            begin
                tick_count_next  = '0;
                speed_next       = pulse_inc;
                pulse_count_next = '0;
                if (pulse_inc > target_reg)
                begin
                    if (duty_reg > DutyFloor)
                    begin
                        duty_next = duty_reg - {{(DutyW-1){1'b0}}, 1'b1};
                    end
                end
                else if (pulse_inc < target_reg)
                begin
                    duty_next = (duty_reg < cfg.pwm_period)
                              ? duty_reg + {{(DutyW-1){1'b0}}, 1'b1}
                              : cfg.pwm_period;
                end
            end
        end

        if (in_item_reg.pwm_tick)
        begin
            phase_sum = {1'b0, phase_reg} + {{(PhaseW+1-DutyW){1'b0}}, duty_next};
            if (phase_sum > {{(PhaseW+1-PeriodW){1'b0}}, cfg.pwm_period})
            begin
                drive_next = 1'b0;
                phase_sum  = phase_sum - {{(PhaseW+1-PeriodW){1'b0}}, cfg.pwm_period};
            end
            else
            begin
                drive_next = 1'b1;
            end
            phase_next = phase_sum[PhaseW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            pulse_count_reg <= '0;
            speed_reg       <= '0;
            tick_count_reg  <= '0;
            target_reg      <= TargetReset;
            duty_reg        <= DutyReset;
            phase_reg       <= '0;
            drive_reg       <= 1'b1;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (adv)
            begin
                pulse_count_reg <= pulse_count_next;
                speed_reg       <= speed_next;
                tick_count_reg  <= tick_count_next;
                target_reg      <= target_next;
                duty_reg        <= duty_next;
                phase_reg       <= phase_next;
                drive_reg       <= drive_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            in_item_reg <= in_item_t'(s_axis_tdata[$bits(in_item_t)-1:0]);
        end
        if (adv)
        begin
            out_item_reg.drive_level    <= drive_next;
            out_item_reg.measured_speed <= speed_next;
            out_item_reg.duty_count     <= duty_next;
            out_item_reg.active_target  <= target_next;
        end
    end

endmodule

// ===== rtl/mssc_cfg.sv =====
// ----------------------------------------------------------------------------
// mssc_cfg
// apb register file holding targets, pwm period and window length
// ----------------------------------------------------------------------------
module mssc_cfg
    import mssc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ApbAddrW-1:0] paddr,
    input  logic [ApbDataW-1:0] pwdata,
    output logic [ApbDataW-1:0] prdata,
    output cfg_t                cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    cfg_reg_t sel;

    assign sel = cfg_reg_t'(paddr[ApbAddrW-1:2]);
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            case (sel)
                REG_HIGH_TARGET:  cfg_next.high_target  = pwdata[TargetW-1:0];
                REG_LOW_TARGET:   cfg_next.low_target   = pwdata[TargetW-1:0];
                REG_PWM_PERIOD:   cfg_next.pwm_period   = pwdata[PeriodW-1:0];
                REG_WINDOW_TICKS: cfg_next.window_ticks = pwdata[WindowW-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            REG_HIGH_TARGET:  prdata = {{(ApbDataW-TargetW){1'b0}}, cfg_reg.high_target};
            REG_LOW_TARGET:   prdata = {{(ApbDataW-TargetW){1'b0}}, cfg_reg.low_target};
            REG_PWM_PERIOD:   prdata = {{(ApbDataW-PeriodW){1'b0}}, cfg_reg.pwm_period};
            REG_WINDOW_TICKS: prdata = {{(ApbDataW-WindowW){1'b0}}, cfg_reg.window_ticks};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.high_target  <= HighTargetReset;
            cfg_reg.low_target   <= LowTargetReset;
            cfg_reg.pwm_period   <= PeriodReset;
            cfg_reg.window_ticks <= WindowReset;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/mssc_checker.sv =====
// ----------------------------------------------------------------------------
// mssc_checker
// port level checks of the motor speed step controller
// ----------------------------------------------------------------------------
module mssc_checker
    import mssc_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                psel,
    input logic                penable,
    input logic                pwrite,
    input logic [ApbAddrW-1:0] paddr,
    input logic [ApbDataW-1:0] pwdata,
    input logic [ApbDataW-1:0] prdata,
    input logic                pready,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic [InDataW-1:0]  s_axis_tdata,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [OutDataW-1:0] m_axis_tdata
);

    logic wr_high;
    logic rd_high;

    assign wr_high = psel && penable && pwrite && pready
                  && (paddr[ApbAddrW-1:2] == REG_HIGH_TARGET);
    assign rd_high = psel && !pwrite && (paddr[ApbAddrW-1:2] == REG_HIGH_TARGET);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // empty output never blocks the input side
    a_no_idle_block: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // an accepted item reaches the output when the sink is ready
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready |=> m_axis_tvalid)
        else $error("accepted item did not reach the output");

    // register read back after a write
    a_readback: assert property (@(posedge clk) disable iff (!rst_n)
        wr_high ##1 rd_high |-> prdata[TargetW-1:0] == $past(pwdata[TargetW-1:0]))
        else $error("high target read back mismatch");

endmodule

bind motor_speed_step_controller mssc_checker u_mssc_checker (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// checks every status transfer of the motor speed step controller against a
// cycle-free model of pulse counting, window stepping of the duty and the
// accumulator pwm, over several register settings and with random stalls
// ----------------------------------------------------------------------------
module tb_top
    import mssc_pkg::*;
();

    localparam int ClkHalf     = 2;
    localparam int CycleLimit  = 200000;
    localparam int HoldCycles  = 60;
    localparam int DrainCycles = 8;

    typedef enum int {
        BTN_ANY,
        BTN_LOW,
        BTN_HIGH
    } button_bias_t;

    logic                clk;
    logic                rst_n         = 1'b0;
    logic                psel          = 1'b0;
    logic                penable       = 1'b0;
    logic                pwrite        = 1'b0;
    logic [ApbAddrW-1:0] paddr         = '0;
    logic [ApbDataW-1:0] pwdata        = '0;
    logic [ApbDataW-1:0] prdata;
    logic                pready;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [InDataW-1:0]  s_axis_tdata  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OutDataW-1:0] m_axis_tdata;

    in_item_t  steps_pending[$];
    out_item_t status_due[$];

    // controller model: registers and state
    logic [TargetW-1:0] set_high;
    logic [TargetW-1:0] set_low;
    logic [PeriodW-1:0] set_period;
    logic [WindowW-1:0] set_window;
    logic [CountW-1:0]  pulses;
    logic [CountW-1:0]  speed;
    logic [WindowW-1:0] ticks;
    logic [TargetW-1:0] target;
    logic [DutyW-1:0]   duty;
    logic [PhaseW-1:0]  phase;
    logic               drive;

    bit          send_idle     = 1'b0;
    bit          sink_idle     = 1'b0;
    int          send_gap;
    int unsigned sink_wait;
    int          hold_token    = 0;
    int          hold_seen;
    int          items_sent    = 0;
    int          results_seen  = 0;
    int          errors_seen   = 0;
    int          settings_used = 0;
    int          cycles        = 0;

    motor_speed_step_controller i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    function automatic out_item_t advance_controller(in_item_t st);
        int unsigned sum;
        out_item_t   res;
        if (st.tach_pulse && pulses != CountMax)
            pulses = pulses + 1'b1;
        if (st.slow_tick)
        begin
            if (int'(ticks) + 1 < int'(set_window))
            begin
                ticks = ticks + 1'b1;
                if (!st.low_button_n)
                    target = set_low;
                else if (!st.high_button_n)
                    target = set_high;
            end
            else
            begin
                ticks  = '0;
                speed  = pulses;
                pulses = '0;
                if (speed > target)
                begin
                    if (duty > DutyFloor)
                        duty = duty - 1'b1;
                end
                else if (speed < target)
                    duty = (duty < set_period) ? duty + 1'b1 : set_period;
            end
        end
        if (st.pwm_tick)
        begin
            sum = int'(phase) + int'(duty);
            if (sum > int'(set_period))
            begin
                drive = 1'b0;
                sum   = sum - int'(set_period);
            end
            else
                drive = 1'b1;
            phase = sum[PhaseW-1:0];
        end
        res.drive_level    = drive;
        res.measured_speed = speed;
        res.duty_count     = duty;
        res.active_target  = target;
        return res;
    endfunction

    function automatic void push_step(bit tach, bit slow, bit pwm, bit low_n, bit high_n);
        in_item_t st;
        st.tach_pulse    = tach;
        st.slow_tick     = slow;
        st.pwm_tick      = pwm;
        st.low_button_n  = low_n;
        st.high_button_n = high_n;
        steps_pending.push_back(st);
    endfunction

    // probabilities in sixteenths
    function automatic void queue_random(int n, int p_tach, int p_slow, int p_pwm,
                                         button_bias_t bias);
        bit low_n;
        bit high_n;
        for (int i = 0; i < n; i++)
        begin
            case (bias)
                BTN_LOW:
                begin
                    low_n  = ($urandom_range(0, 7) == 0);
                    high_n = 1'($urandom_range(0, 1));
                end
                BTN_HIGH:
                begin
                    low_n  = ($urandom_range(0, 7) != 0);
                    high_n = ($urandom_range(0, 7) == 0);
                end
                default:
                begin
                    low_n  = 1'($urandom_range(0, 1));
                    high_n = 1'($urandom_range(0, 1));
                end
            endcase
            push_step($urandom_range(0, 15) < p_tach, $urandom_range(0, 15) < p_slow,
                      $urandom_range(0, 15) < p_pwm, low_n, high_n);
        end
    endfunction

    task automatic apb_write(cfg_reg_t idx, logic [ApbDataW-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ApbAddrW'(idx) << 2;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_HIGH_TARGET:  set_high   = value[TargetW-1:0];
            REG_LOW_TARGET:   set_low    = value[TargetW-1:0];
            REG_PWM_PERIOD:   set_period = value[PeriodW-1:0];
            REG_WINDOW_TICKS: set_window = value[WindowW-1:0];
            default: ;
        endcase
    endtask

    task automatic program_controller(logic [TargetW-1:0] hi, logic [TargetW-1:0] lo,
                                      logic [PeriodW-1:0] per, logic [WindowW-1:0] win);
        apb_write(REG_HIGH_TARGET, ApbDataW'(hi));
        apb_write(REG_LOW_TARGET, ApbDataW'(lo));
        apb_write(REG_PWM_PERIOD, ApbDataW'(per));
        apb_write(REG_WINDOW_TICKS, ApbDataW'(win));
        settings_used++;
        @(negedge clk);
    endtask

    task automatic wait_quiet();
        while (steps_pending.size() != 0 || s_axis_tvalid || status_due.size() != 0)
            @(negedge clk);
        repeat (DrainCycles) @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #ClkHalf clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // step driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            send_gap      <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                status_due.push_back(
                    advance_controller(in_item_t'(s_axis_tdata[$bits(in_item_t)-1:0])));
                items_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap != 0)
                begin
                    send_gap      <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (steps_pending.size() != 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= InDataW'(steps_pending.pop_front());
                    send_gap      <= send_idle ? $urandom_range(0, 7) : 0;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // status monitor
    always @(posedge clk or negedge rst_n)
    begin : status_sink
        int unsigned wait_next;
        out_item_t   got;
        out_item_t   want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_wait     <= 0;
            hold_seen     <= 0;
        end
        else
        begin
            wait_next = sink_wait;
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = out_item_t'(m_axis_tdata[$bits(out_item_t)-1:0]);
                results_seen++;
                if (status_due.size() == 0)
                begin
                    $error("status transfer with nothing expected: %h", m_axis_tdata);
                    errors_seen++;
                end
                else
                begin
                    want = status_due.pop_front();
                    if (got.drive_level !== want.drive_level)
                    begin
                        $error("drive_level: expected %0d, actual %0d",
                               want.drive_level, got.drive_level);
                        errors_seen++;
                    end
                    if (got.measured_speed !== want.measured_speed)
                    begin
                        $error("measured_speed: expected %0d, actual %0d",
                               want.measured_speed, got.measured_speed);
                        errors_seen++;
                    end
                    if (got.duty_count !== want.duty_count)
                    begin
                        $error("duty_count: expected %0d, actual %0d",
                               want.duty_count, got.duty_count);
                        errors_seen++;
                    end
                    if (got.active_target !== want.active_target)
                    begin
                        $error("active_target: expected %0d, actual %0d",
                               want.active_target, got.active_target);
                        errors_seen++;
                    end
                end
                wait_next = sink_idle ? $urandom_range(0, 7) : 0;
            end
            else if (wait_next != 0)
                wait_next--;
            if (hold_token != hold_seen)
            begin
                wait_next = HoldCycles;
                hold_seen <= hold_token;
            end
            sink_wait     <= wait_next;
            m_axis_tready <= (wait_next == 0);
        end
    end

    initial
    begin
        set_high   = HighTargetReset;
        set_low    = LowTargetReset;
        set_period = PeriodReset;
        set_window = WindowReset;
        pulses     = '0;
        speed      = '0;
        ticks      = '0;
        target     = TargetReset;
        duty       = DutyReset;
        phase      = '0;
        drive      = 1'b1;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // reset settings, every event and button mix
        push_step(0, 0, 0, 1, 1);
        push_step(1, 0, 0, 1, 1);
        push_step(0, 1, 0, 1, 0);
        push_step(0, 1, 0, 0, 1);
        push_step(0, 1, 0, 0, 0);
        push_step(0, 1, 0, 1, 0);
        push_step(0, 1, 0, 1, 1);
        push_step(0, 0, 1, 1, 1);
        push_step(1, 1, 1, 0, 0);
        push_step(1, 1, 1, 1, 1);
        push_step(0, 0, 0, 0, 0);
        push_step(1, 0, 1, 1, 0);
        repeat (10) push_step(0, 0, 1, 1, 1);
        wait_quiet();

        // short window below the running count, low target of zero drives duty to its floor
        program_controller(8'd255, 8'd0, 10'd1023, 5'd2);
        send_idle = 1'b1;
        sink_idle = 1'b1;
        queue_random(60, 12, 12, 8, BTN_LOW);
        wait_quiet();

        // high target above reach, duty climbs to a small period
        program_controller(8'd200, 8'd3, 10'd40, 5'd2);
        sink_idle = 1'b0;
        queue_random(60, 2, 8, 12, BTN_HIGH);
        wait_quiet();

        // zero-tick window and a period below the floor, phase wraps
        program_controller(8'd0, 8'd255, 10'd1, 5'd0);
        send_idle = 1'b0;
        sink_idle = 1'b1;
        queue_random(60, 8, 8, 12, BTN_ANY);
        wait_quiet();

        // pulse count saturation in a one-tick window
        program_controller(8'd120, 8'd75, 10'd3, 5'd1);
        sink_idle = 1'b0;
        queue_random(262, 16, 0, 8, BTN_ANY);
        push_step(0, 1, 0, 1, 1);
        queue_random(20, 8, 8, 8, BTN_ANY);
        wait_quiet();

        // random settings with a long output stall
        for (int k = 0; k < 2; k++)
        begin
            program_controller(TargetW'($urandom_range(0, 255)),
                               TargetW'($urandom_range(0, 255)),
                               PeriodW'($urandom_range(3, 120)),
                               (k == 0) ? WindowW'($urandom_range(3, 6)) : WindowW'(31));
            send_idle = 1'b1;
            sink_idle = 1'b1;
            queue_random(60, 8, 6, 10, BTN_ANY);
            repeat (20) @(negedge clk);
            hold_token++;
            wait_quiet();
        end

        $display("covered %0d step transfers, %0d status transfers, %0d register settings",
                 items_sent, results_seen, settings_used);
        if (errors_seen == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== motor_speed_step_controller.f =====
rtl/mssc_pkg.sv
rtl/mssc_cfg.sv
rtl/motor_speed_step_controller.sv
rtl/mssc_checker.sv
bench/tb_top.sv
